/* rtl/core/ppft_pkg.sv */
// ----------------------------------------------------------------------------
// ppft_pkg: shared types and constants of the pulse peak timing core
// Register indexes, fixed field widths, the waveform summary word that
// passes from the front to the back, and the arithmetic widths of the back.
// ----------------------------------------------------------------------------
package ppft_pkg;

  // Configuration register indexes
  localparam logic CFG_SEARCH_WINDOW   = 1'b0;
  localparam logic CFG_FRACTION_TENTHS = 1'b1;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 11;

  localparam logic [10:0] WindowReset   = 11'd51;
  localparam logic [3:0]  FractionReset = 4'd8;

  // Field widths
  localparam int unsigned SampleW = 16;
  localparam int unsigned PeakW   = 15;
  localparam int unsigned PosW    = 13;   // holds a peak position up to 4096
  localparam int unsigned PosOutW = 11;
  localparam int unsigned WinW    = 11;
  localparam int unsigned FracW   = 4;
  localparam int unsigned TimeW   = 24;

  // Back arithmetic widths
  localparam int unsigned X1W   = 14;  // peak position plus two, signed
  localparam int unsigned DiffW = 17;  // second minus first capture
  localparam int unsigned D10W  = 21;  // ten times the difference
  localparam int unsigned TermW = 22;  // 2*(frac*peak - 10*y1)
  localparam int unsigned ProdW = 35;  // x1 * 10 * d
  localparam int unsigned NumW  = 36;  // full numerator before scaling
  localparam int unsigned DenW  = 20;  // magnitude of ten times the difference

  localparam logic [63:0] TimeMaxMag = 64'd8388607;
  localparam logic [63:0] TimeMinMag = 64'd8388608;
  localparam logic [TimeW-1:0] TimeMax = 24'h7FFFFF;
  localparam logic [TimeW-1:0] TimeMin = 24'h800000;

  // Queue depth between front and back
  localparam int unsigned QueueDepth = 2;

  // Summary of one finished waveform
  typedef struct packed {
    logic signed [SampleW-1:0] first_capture;
    logic signed [SampleW-1:0] second_capture;
    logic [PeakW-1:0]          peak;
    logic [PosW-1:0]           peak_pos;
    logic [FracW-1:0]          fraction;
  } wave_t;

  // Finished result as it leaves the back
  typedef struct packed {
    logic signed [TimeW-1:0] crossing_time;
    logic [PeakW-1:0]        peak;
    logic [PosOutW-1:0]      peak_pos;
    logic                    zero_slope;
  } result_t;

endpackage

/* rtl/core/ppft_front.sv */
// ----------------------------------------------------------------------------
// ppft_front: per-sample peak search and capture
// Tracks the running peak over the search window and the samples two and four
// places after it, and emits one summary word per waveform on its last sample.
// ----------------------------------------------------------------------------
module ppft_front #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned MAX_WINDOW  = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [ppft_pkg::SampleW-1:0]  sample_i,
  input  logic                          last_sample_i,
  input  logic [ppft_pkg::WinW-1:0]     search_window_i,
  input  logic [ppft_pkg::FracW-1:0]    fraction_tenths_i,
  output logic                          push_o,
  output ppft_pkg::wave_t               wave_o
);

  localparam int unsigned IdxCap = MAX_WINDOW + 5;
  localparam int unsigned IdxW   = $clog2(IdxCap + 1);

  logic [IdxW-1:0]                       idx_q, idx_d;
  logic [ppft_pkg::PeakW-1:0]            peak_q, peak_d;
  logic [ppft_pkg::PosW-1:0]             pos_q, pos_d;
  logic signed [ppft_pkg::SampleW-1:0]   y1_q, y1_d, y2_q, y2_d;
  logic signed [ppft_pkg::SampleW-1:0]   s;
  logic [31:0]                           win;
  logic                                  new_peak;

  // Sign-extend the sample from its significant bits
  assign s = ppft_pkg::SampleW'(signed'(sample_i[SAMPLE_BITS-1:0]));

  // Clamp the window to the largest supported search
  assign win = (32'(search_window_i) > 32'(MAX_WINDOW)) ? 32'(MAX_WINDOW)
                                                         : 32'(search_window_i);

  // Advance the search for this word
  always_comb begin
    idx_d = (32'(idx_q) < 32'(IdxCap)) ? idx_q + IdxW'(1) : idx_q;
    new_peak = (32'(idx_d) <= win) && (s > signed'({1'b0, peak_q}));
    peak_d = peak_q;
    pos_d  = pos_q;
    y1_d   = y1_q;
    y2_d   = y2_q;
    if (new_peak) begin
      peak_d = s[ppft_pkg::PeakW-1:0];
      pos_d  = ppft_pkg::PosW'(idx_d);
      y1_d   = '0;
      y2_d   = '0;
    end
    if (32'(idx_d) == 32'(pos_d) + 32'd2) begin
      y1_d = s;
    end
    if (32'(idx_d) == 32'(pos_d) + 32'd4) begin
      y2_d = s;
    end
  end

  // Hand off the summary on the last word
  assign push_o = accept_i && last_sample_i;
  assign wave_o = '{first_capture:  y1_d,
                    second_capture: y2_d,
                    peak:           peak_d,
                    peak_pos:       pos_d,
                    fraction:       fraction_tenths_i};

  // Hold state, clear it after each waveform
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      peak_q <= '0;
      pos_q  <= '0;
      y1_q   <= '0;
      y2_q   <= '0;
    end else if (accept_i) begin
      if (last_sample_i) begin
        idx_q  <= '0;
        peak_q <= '0;
        pos_q  <= '0;
        y1_q   <= '0;
        y2_q   <= '0;
      end else begin
        idx_q  <= idx_d;
        peak_q <= peak_d;
        pos_q  <= pos_d;
        y1_q   <= y1_d;
        y2_q   <= y2_d;
      end
    end
  end

endmodule

/* rtl/core/ppft_queue.sv */
// ----------------------------------------------------------------------------
// ppft_queue: two-entry queue of waveform summaries
// Lets the front keep taking samples while the back divides.
// ----------------------------------------------------------------------------
module ppft_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ppft_pkg::wave_t wave_i,
  input  logic            pop_i,
  output logic            valid_o,
  output logic            full_o,
  output ppft_pkg::wave_t wave_o
);

  localparam int unsigned PtrW = $clog2(ppft_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(ppft_pkg::QueueDepth + 1);

  ppft_pkg::wave_t mem_q [ppft_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (32'(cnt_q) == ppft_pkg::QueueDepth);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign wave_o  = mem_q[rd_ptr_q];

  // Store pushed words
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wave_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

/* rtl/core/ppft_back.sv */
// ----------------------------------------------------------------------------
// ppft_back: crossing time arithmetic and output register
// Builds numerator and denominator of the interpolated crossing, divides
// one quotient bit per cycle, saturates and holds the result word.
// ----------------------------------------------------------------------------
module ppft_back #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  ppft_pkg::wave_t   wave_i,
  output logic              pop_o,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output ppft_pkg::result_t result_o
);

  localparam int unsigned MagW = ppft_pkg::NumW + FRAC_BITS;
  localparam int unsigned CntW = $clog2(MagW + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_SUM  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]                          state_q, state_d;
  logic signed [ppft_pkg::X1W-1:0]     x1_q;
  logic signed [ppft_pkg::D10W-1:0]    d10_q;
  logic signed [ppft_pkg::TermW-1:0]   term_q;
  logic signed [ppft_pkg::ProdW-1:0]   prod_q;
  logic                                flat_q, neg_q;
  logic [ppft_pkg::PeakW-1:0]          peak_q;
  logic [ppft_pkg::PosW-1:0]           pos_q;
  logic [MagW-1:0]                     quo_q;
  logic [ppft_pkg::DenW-1:0]           den_q, rem_q;
  logic [CntW-1:0]                     cnt_q;
  logic                                out_valid_q;
  ppft_pkg::result_t                   result_q;

  logic signed [ppft_pkg::DiffW-1:0]   diff;
  logic signed [ppft_pkg::D10W-1:0]    d10;
  logic [18:0]                         frac_peak;
  logic signed [ppft_pkg::D10W-1:0]    y1_10;
  logic signed [ppft_pkg::NumW-1:0]    num;
  logic [ppft_pkg::NumW-1:0]           num_mag;
  logic [ppft_pkg::D10W-1:0]           d10_abs;
  logic [ppft_pkg::DenW:0]             rem_sh;
  logic                                rem_ge;
  logic [63:0]                         quo_ext;
  logic [ppft_pkg::TimeW-1:0]          quo_lo;
  logic [ppft_pkg::TimeW-1:0]          time_sat;
  logic [31:0]                         pos_ext;
  logic                                take_out, out_free;

  // Prepare terms from the queue head
  assign diff = ppft_pkg::DiffW'(wave_i.second_capture) -
                ppft_pkg::DiffW'(wave_i.first_capture);
  assign d10 = ppft_pkg::D10W'(diff) * 21'sd10;
  assign frac_peak = 19'(wave_i.fraction) * 19'(wave_i.peak);
  assign y1_10 = ppft_pkg::D10W'(wave_i.first_capture) * 21'sd10;

  // Combine numerator and take magnitudes
  assign num = ppft_pkg::NumW'(prod_q) + ppft_pkg::NumW'(term_q);
  assign num_mag = num[ppft_pkg::NumW-1] ? ppft_pkg::NumW'(-num) : ppft_pkg::NumW'(num);
  assign d10_abs = d10_q[ppft_pkg::D10W-1] ? ppft_pkg::D10W'(-d10_q)
                                           : ppft_pkg::D10W'(d10_q);

  // One restoring division step
  assign rem_sh = {rem_q, quo_q[MagW-1]};
  assign rem_ge = (rem_sh >= {1'b0, den_q});

  // Saturate the quotient to the time range
  assign quo_ext = 64'(quo_q);
  assign quo_lo  = quo_q[ppft_pkg::TimeW-1:0];
  always_comb begin
    if (flat_q) begin
      time_sat = '0;
    end else if (neg_q) begin
      time_sat = (quo_ext > ppft_pkg::TimeMinMag) ? ppft_pkg::TimeMin
                                                  : ppft_pkg::TimeW'(-quo_lo);
    end else begin
      time_sat = (quo_ext > ppft_pkg::TimeMaxMag) ? ppft_pkg::TimeMax : quo_lo;
    end
  end

  assign pos_ext  = 32'(pos_q);
  assign take_out = out_valid_q && !out_stall_i;
  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = (state_q == ST_IDLE) && q_valid_i;

  // Sequence one waveform through the arithmetic
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (q_valid_i) state_d = ST_MUL;
      ST_MUL:  state_d = ST_SUM;
      ST_SUM:  state_d = flat_q ? ST_DONE : ST_DIV;
      ST_DIV:  if (32'(cnt_q) == MagW - 1) state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (take_out) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        x1_q   <= ppft_pkg::X1W'(wave_i.peak_pos) + 14'sd2;
        d10_q  <= d10;
        term_q <= ppft_pkg::TermW'(ppft_pkg::TermW'(frac_peak) -
                                   ppft_pkg::TermW'(y1_10)) <<< 1;
        flat_q <= (diff == '0);
        peak_q <= wave_i.peak;
        pos_q  <= wave_i.peak_pos;
      end
      ST_MUL: begin
        prod_q <= ppft_pkg::ProdW'(x1_q) * ppft_pkg::ProdW'(d10_q);
      end
      ST_SUM: begin
        neg_q <= num[ppft_pkg::NumW-1] ^ d10_q[ppft_pkg::D10W-1];
        quo_q <= MagW'(num_mag) << FRAC_BITS;
        den_q <= ppft_pkg::DenW'(d10_abs);
        rem_q <= '0;
        cnt_q <= '0;
      end
      ST_DIV: begin
        rem_q <= rem_ge ? ppft_pkg::DenW'(rem_sh - {1'b0, den_q})
                        : rem_sh[ppft_pkg::DenW-1:0];
        quo_q <= {quo_q[MagW-2:0], rem_ge};
        cnt_q <= cnt_q + CntW'(1);
      end
      ST_DONE: begin
        if (out_free) begin
          result_q <= '{crossing_time: time_sat,
                        peak:          peak_q,
                        peak_pos:      pos_ext[ppft_pkg::PosOutW-1:0],
                        zero_slope:    flat_q};
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule

/* rtl/core/pulse_peak_fraction_timing_core.sv */
// ----------------------------------------------------------------------------
// pulse_peak_fraction_timing_core: pulse peak and fractional crossing time
// Finds the peak of each waveform and times its falling-edge crossing of a
// programmable fraction of the peak by linear interpolation.
//
//   channel | signals                                  | moves
//   --------+------------------------------------------+------------------
//   in      | in_valid_i, in_stall_o, sample_i, last   | one sample word
//   out     | out_valid_o, out_stall_i, result fields  | one result word
//   cfg     | cfg_we_i, cfg_idx_i, cfg_wdata_i         | one register write
//
// Samples are taken one per cycle while the summary queue has room.
// Each waveform then passes through the back's multiply, sum and divide steps,
// one quotient bit per cycle in the divider; zero slope skips the divide.
// Reset clears the search state, the queue and the output valid flag.
// A stalled result holds the back, which then fills the queue and stalls input.
// ----------------------------------------------------------------------------
module pulse_peak_fraction_timing_core #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned MAX_WINDOW  = 1024,
  parameter int unsigned FRAC_BITS   = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ppft_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ppft_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [15:0]             sample_i,
  input  logic                           last_sample_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [23:0]             crossing_time_q8_o,
  output logic [14:0]                    peak_value_o,
  output logic [10:0]                    peak_position_o,
  output logic                           zero_slope_o
);

  logic [ppft_pkg::WinW-1:0]  search_window_q;
  logic [ppft_pkg::FracW-1:0] fraction_tenths_q;
  logic                       accept, push, q_full, q_valid, pop;
  ppft_pkg::wave_t            wave_push, wave_head;
  ppft_pkg::result_t          result;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      search_window_q   <= ppft_pkg::WindowReset;
      fraction_tenths_q <= ppft_pkg::FractionReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ppft_pkg::CFG_SEARCH_WINDOW:   search_window_q   <= cfg_wdata_i;
        ppft_pkg::CFG_FRACTION_TENTHS: fraction_tenths_q <= cfg_wdata_i[3:0];
        default: begin
        end
      endcase
    end
  end

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  ppft_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_WINDOW  (MAX_WINDOW)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (accept),
    .sample_i          (sample_i),
    .last_sample_i     (last_sample_i),
    .search_window_i   (search_window_q),
    .fraction_tenths_i (fraction_tenths_q),
    .push_o            (push),
    .wave_o            (wave_push)
  );

  ppft_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wave_i  (wave_push),
    .pop_i   (pop),
    .valid_o (q_valid),
    .full_o  (q_full),
    .wave_o  (wave_head)
  );

  ppft_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .wave_i      (wave_head),
    .pop_o       (pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .result_o    (result)
  );

  assign crossing_time_q8_o = result.crossing_time;
  assign peak_value_o       = result.peak;
  assign peak_position_o    = result.peak_pos;
  assign zero_slope_o       = result.zero_slope;

endmodule

/* rtl/core/ppft_checker.sv */
// ----------------------------------------------------------------------------
// ppft_checker: port-level checks of the pulse peak timing core
// Watches the result channel for holding under stall and consistent fields.
// ----------------------------------------------------------------------------
module ppft_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [23:0] crossing_time_q8_o,
  input logic [14:0]        peak_value_o,
  input logic [10:0]        peak_position_o,
  input logic               zero_slope_o
);

  // Hold a stalled result word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o &&
      $stable(crossing_time_q8_o) && $stable(peak_value_o) &&
      $stable(peak_position_o) && $stable(zero_slope_o))
    else $error("stalled result word changed");

  // Flat captures give no time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_slope_o |-> crossing_time_q8_o == 24'sd0)
    else $error("zero slope with nonzero time");

  // No peak means no position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && peak_value_o == 15'd0 |-> peak_position_o == 11'd0)
    else $error("zero peak with nonzero position");

endmodule

bind pulse_peak_fraction_timing_core ppft_checker u_ppft_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .crossing_time_q8_o (crossing_time_q8_o),
  .peak_value_o       (peak_value_o),
  .peak_position_o    (peak_position_o),
  .zero_slope_o       (zero_slope_o)
);

/* verif/tb_pulse_peak_fraction_timing_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pulse_peak_fraction_timing_core: self-checking bench for the pulse timing core
// Streams waveforms through the sample channel and predicts each result word
// from an internal copy of the search and interpolation state. Every result
// word is checked field by field in order. Directed waveforms come first,
// then random pulses, noise and flat runs over several register settings,
// with random idling on both channels in all but the last two settings.
// ----------------------------------------------------------------------------

// Tracks the peak search per waveform and holds the expected result words
class pulse_timing_board;
  localparam int unsigned MaxWindow = 1024;
  localparam int unsigned FracBits  = 8;
  localparam longint      TimeHi    = 64'sd8388607;
  localparam longint      TimeLo    = -64'sd8388608;

  int unsigned       window = ppft_pkg::WindowReset;
  int unsigned       frac   = ppft_pkg::FractionReset;
  int unsigned       index;
  int unsigned       peak_pos;
  int                peak;
  int                first_cap;
  int                second_cap;
  ppft_pkg::result_t pending_results[$];
  int unsigned       errors;

  // Advance the search by one accepted sample word
  function void take_sample(logic signed [15:0] word, logic last);
    int                value;
    int unsigned       win;
    longint            y1;
    longint            y2;
    longint            diff;
    longint            num;
    longint            den;
    longint            t;
    ppft_pkg::result_t want;
    value = word;
    win = (window > MaxWindow) ? MaxWindow : window;
    if (index < MaxWindow + 5) index++;
    // A new peak moves the capture points, so drop old captures
    if (index <= win && value > peak) begin
      peak = value;
      peak_pos = index;
      first_cap = 0;
      second_cap = 0;
    end
    if (index == peak_pos + 2) first_cap = value;
    if (index == peak_pos + 4) second_cap = value;
    if (!last) return;

    // Interpolate the crossing of frac/10 of the peak between the captures
    y1 = first_cap;
    y2 = second_cap;
    diff = y2 - y1;
    t = 0;
    if (diff != 0) begin
      num = (longint'(peak_pos) + 2) * 10 * diff
          + 2 * (longint'(frac) * peak - 10 * y1);
      den = 10 * diff;
      if (den < 0) begin
        den = -den;
        num = -num;
      end
      t = (num * (longint'(1) << FracBits)) / den;
      if (t > TimeHi) t = TimeHi;
      if (t < TimeLo) t = TimeLo;
    end
    want.crossing_time = t[23:0];
    want.peak          = peak[14:0];
    want.peak_pos      = peak_pos[10:0];
    want.zero_slope    = (diff == 0);
    pending_results = {pending_results, want};

    index = 0;
    peak = 0;
    peak_pos = 0;
    first_cap = 0;
    second_cap = 0;
  endfunction

  task report(string what, longint got, longint want);
    if (errors < 40) $display("mismatch on %s: got %0d, want %0d", what, got, want);
    errors++;
  endtask

  // Compare one accepted result word with the oldest expectation
  task check_result(ppft_pkg::result_t got);
    ppft_pkg::result_t want;
    if (pending_results.size() == 0) begin
      report("result word with no waveform pending", 0, 0);
      return;
    end
    want = pending_results.pop_front();
    if (got.crossing_time !== want.crossing_time)
      report("crossing_time_q8", got.crossing_time, want.crossing_time);
    if (got.peak !== want.peak) report("peak_value", got.peak, want.peak);
    if (got.peak_pos !== want.peak_pos)
      report("peak_position", got.peak_pos, want.peak_pos);
    if (got.zero_slope !== want.zero_slope)
      report("zero_slope", got.zero_slope, want.zero_slope);
  endtask
endclass

module tb_pulse_peak_fraction_timing_core;

  localparam int unsigned StuckLimit = 4000;
  localparam int unsigned SettleCycles = 60;
  localparam int unsigned PhaseItems = 85;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i;
  logic [ppft_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [ppft_pkg::CfgDataW-1:0] cfg_wdata_i;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic signed [15:0]            sample_i;
  logic                          last_sample_i;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic signed [23:0]            crossing_time_q8_o;
  logic [14:0]                   peak_value_o;
  logic [10:0]                   peak_position_o;
  logic                          zero_slope_o;

  int unsigned in_idle_pct = 0;
  int unsigned out_stall_pct = 0;
  int unsigned stuck_cycles = 0;

  int unsigned phase_window[5] = '{1024, 1, 0, 7, 2047};
  int unsigned phase_frac[5]   = '{9, 1, 0, 15, 5};

  pulse_timing_board timing = new();

  pulse_peak_fraction_timing_core u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .sample_i           (sample_i),
    .last_sample_i      (last_sample_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .crossing_time_q8_o (crossing_time_q8_o),
    .peak_value_o       (peak_value_o),
    .peak_position_o    (peak_position_o),
    .zero_slope_o       (zero_slope_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Stall the result channel at random
  always @(posedge clk_i) begin
    out_stall_i <= (out_stall_pct != 0) && ($urandom_range(99) < out_stall_pct);
  end

  // Observe both channels at the edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) timing.take_sample(sample_i, last_sample_i);
      if (out_valid_o && !out_stall_i)
        timing.check_result(ppft_pkg::result_t'{crossing_time_q8_o, peak_value_o,
                                                peak_position_o, zero_slope_o});
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles == StuckLimit) begin
      $display("tb_pulse_peak_fraction_timing_core: done, errors");
      $finish;
    end
  end

  // Present one sample word, with random idle cycles ahead of it
  task automatic send_word(input logic signed [15:0] word, input logic last);
    while (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    sample_i      <= word;
    last_sample_i <= last;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_wave(input int wave[$]);
    foreach (wave[i]) send_word(16'(wave[i]), i == wave.size() - 1);
  endtask

  // Hold the sample channel until every expected result word has come
  task automatic wait_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (timing.pending_results.size() != 0);
  endtask

  task automatic program_regs(input int unsigned win, input int unsigned frac);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= ppft_pkg::CFG_SEARCH_WINDOW;
    cfg_wdata_i <= ppft_pkg::CfgDataW'(win);
    @(posedge clk_i);
    // Junk in the upper data bits must be ignored by the fraction register
    cfg_idx_i   <= ppft_pkg::CFG_FRACTION_TENTHS;
    cfg_wdata_i <= {7'($urandom), 4'(frac)};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    timing.window = win;
    timing.frac = frac;
    @(posedge clk_i);
  endtask

  task automatic set_idling(input int unsigned mode);
    case (mode)
      0: begin
        in_idle_pct = 10;
        out_stall_pct = 45;
      end
      1: begin
        in_idle_pct = 45;
        out_stall_pct = 10;
      end
      default: begin
        in_idle_pct = 0;
        out_stall_pct = 0;
      end
    endcase
  endtask

  // Rise linearly to the peak, fall with the given slope, add a little noise
  task automatic build_pulse(output int wave[$], input int len, input int pk,
                             input int amp, input int decay);
    int v;
    wave.delete();
    for (int i = 1; i <= len; i++) begin
      if (i <= pk) v = amp * i / pk;
      else v = amp - amp * (i - pk) / decay;
      v += int'($urandom_range(16)) - 8;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      wave = {wave, v};
    end
  endtask

  task automatic run_random(input int unsigned item_goal);
    int          wave[$];
    int unsigned sent;
    int          kind;
    int          len;
    int          pk;
    int          v;
    int          win_eff;
    sent = 0;
    while (sent < item_goal) begin
      kind = $urandom_range(99);
      len = ($urandom_range(9) == 0) ? $urandom_range(41, 70) : $urandom_range(1, 40);
      win_eff = (timing.window > 1024) ? 1024 : timing.window;
      if (kind < 70) begin
        // Mostly keep the peak inside the search window
        if (win_eff == 0 || $urandom_range(4) == 0) pk = $urandom_range(1, len);
        else pk = $urandom_range(1, (len < win_eff) ? len : win_eff);
        build_pulse(wave, len, pk, $urandom_range(1, 32767), $urandom_range(1, 8));
      end else if (kind < 88) begin
        wave.delete();
        repeat (len) wave = {wave, int'($urandom)};
      end else begin
        wave.delete();
        v = int'($urandom_range(65535)) - 32768;
        repeat (len) wave = {wave, v};
      end
      send_wave(wave);
      sent += len;
      if ($urandom_range(7) == 0) wait_results();
    end
  endtask

  initial begin
    in_valid_i    = 1'b0;
    sample_i      = '0;
    last_sample_i = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = ppft_pkg::CFG_SEARCH_WINDOW;
    cfg_wdata_i   = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed waveforms under the reset settings
    set_idling(0);
    send_wave('{32767});                                     // lone peak, no captures
    send_wave('{-32768, -1, -5, -32768, -2});                // nothing positive
    send_wave('{0, 100, 32767, 16000, 8000, 4000, 1000});    // clean pulse
    send_wave('{5, 9, 9, 3, 1, 1, 0});                       // tie keeps the first
    send_wave('{10, 4, 2, 4, 2});                            // equal captures
    run_random(PhaseItems);

    // Walk through the register settings, idle before each write
    for (int p = 0; p < 5; p++) begin
      wait_results();
      repeat (SettleCycles) @(posedge clk_i);
      program_regs(phase_window[p], phase_frac[p]);
      set_idling((p + 1) / 2);
      run_random(PhaseItems);
    end

    wait_results();
    repeat (SettleCycles) @(posedge clk_i);
    if (timing.errors == 0) begin
      $display("tb_pulse_peak_fraction_timing_core: done, clean");
    end else begin
      $display("tb_pulse_peak_fraction_timing_core: done, errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/ppft_pkg.sv
rtl/core/ppft_front.sv
rtl/core/ppft_queue.sv
rtl/core/ppft_back.sv
rtl/core/pulse_peak_fraction_timing_core.sv
rtl/core/ppft_checker.sv
verif/tb_pulse_peak_fraction_timing_core.sv
